/* design/kwm_pkg.sv */
package kwm_pkg;

  localparam int MAX_ENTRIES_DEF = 8;
  localparam int NAME_LEN_DEF    = 16;

  // token field widths cover up to 64 characters, but the 3-bit entry and idx fields cover only 8 entries
  localparam int POS_W = 7;
  localparam int CNT_W = 6;
  localparam int OP_W  = 3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [1:0] OC_END      = 2'd0;
  localparam logic [1:0] OC_MATCH    = 2'd1;
  localparam logic [1:0] OC_NO_MATCH = 2'd2;
  localparam logic [1:0] OC_LIMIT    = 2'd3;

  localparam logic [1:0] CFG_MAX_BYTES = 2'd0;
  localparam logic [1:0] CFG_MAX_TIME  = 2'd1;
  localparam logic [1:0] CFG_SERVICES  = 2'd2;

  localparam logic [15:0] MAX_BYTES_RST = 16'd64;
  localparam logic [15:0] MAX_TIME_RST  = 16'd1000;
  localparam logic [3:0]  SERVICES_RST  = 4'd8;

  localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_START  = 3'd2;
  localparam logic [OP_W-1:0] OP_LETTER = 3'd3;
  localparam logic [OP_W-1:0] OP_EQ     = 3'd4;
  localparam logic [OP_W-1:0] OP_RES    = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             res;
    logic [1:0]       outcome;
    logic [POS_W-1:0] pos;
    logic [7:0]       data;
    logic [2:0]       entry;
    logic             wr;
    logic [CNT_W-1:0] n;
    logic             found;
    logic [2:0]       idx;
  } kwm_tok_t;

endpackage

/* design/kwm_ram.sv */
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/kwm_cell.sv */
module kwm_cell
  import kwm_pkg::*;
#(
  parameter int CELL_IDX = 0,
  parameter int NAME_LEN = NAME_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  kwm_tok_t tok_in,
  output kwm_tok_t tok_out
);

  localparam int AW = $clog2(NAME_LEN);

  kwm_tok_t   a_tok_r;
  kwm_tok_t   b_tok_r;
  kwm_tok_t   b_tok_nxt;
  logic       wflag_r;
  logic       cand_r;
  logic       cand_nxt;
  logic       we;
  logic [AW-1:0] raddr;
  logic [7:0] rdata;
  logic [7:0] ch;
  logic       in_use;

  // stage A: write on load, issue read for the token's position
  assign we    = adv && (tok_in.op == OP_LOAD) && (32'(tok_in.entry) == CELL_IDX);
  assign raddr = (32'(tok_in.pos) >= NAME_LEN) ? '0 : tok_in.pos[AW-1:0];

  kwm_ram #(
    .WIDTH (8),
    .DEPTH (NAME_LEN)
  ) u_name_ram (
    .clk   (clk),
    .we    (we),
    .waddr (tok_in.pos[AW-1:0]),
    .wdata (tok_in.data),
    .re    (adv),
    .raddr (raddr),
    .rdata (rdata)
  );

  // stage B: compare and update candidate bit, and flag a match on an equals sign
  assign ch     = (32'(a_tok_r.pos) >= NAME_LEN) ? CH_NUL : rdata;
  assign in_use = 32'(a_tok_r.n) > CELL_IDX;

  always_comb begin
    b_tok_nxt = a_tok_r;
    cand_nxt  = cand_r;
    case (a_tok_r.op)
      OP_START: begin
        cand_nxt = wflag_r && in_use;
      end
      OP_LETTER: begin
        if (in_use && cand_r && (ch != a_tok_r.data)) begin
          cand_nxt = 1'b0;
        end
      end
      OP_EQ: begin
        if (!a_tok_r.found && in_use && cand_r && (ch == CH_NUL)) begin
          b_tok_nxt.found = 1'b1;
          b_tok_nxt.idx   = 3'(CELL_IDX);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tok_r <= '0;
      b_tok_r <= '0;
      wflag_r <= 1'b0;
      cand_r  <= 1'b0;
    end else if (adv) begin
      a_tok_r <= tok_in;
      b_tok_r <= b_tok_nxt;
      cand_r  <= cand_nxt;
      if (we) begin
        wflag_r <= tok_in.wr;
      end
    end
  end

  assign tok_out = b_tok_r;

endmodule

/* design/kwm_head.sv */
module kwm_head
  import kwm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int NAME_LEN    = NAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        accept,
  input  logic        adv,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_entry_index,
  input  logic [3:0]  in_char_position,
  input  logic [7:0]  in_byte_value,
  input  logic        in_writable,
  output kwm_tok_t    tok_o
);

  logic [15:0]      max_bytes_r;
  logic [15:0]      max_time_r;
  logic [3:0]       svc_r;
  logic             active_r, active_nxt;
  logic [POS_W-1:0] lp_r, lp_nxt, lp_inc;
  logic [15:0]      bytes_r, bytes_nxt, bytes_inc;
  logic [15:0]      ticks_r, ticks_nxt, ticks_inc;
  logic             over, over_after;
  logic [CNT_W-1:0] n_act;
  kwm_tok_t         tok_r, tok_nxt;

  assign ticks_inc  = (ticks_r == 16'hFFFF) ? ticks_r : ticks_r + 16'd1;
  assign bytes_inc  = bytes_r + 16'd1;
  assign over       = (bytes_r >= max_bytes_r) || (ticks_r >= max_time_r);
  assign over_after = (bytes_inc >= max_bytes_r) || (ticks_r >= max_time_r);
  assign lp_inc     = (32'(lp_r) >= NAME_LEN) ? lp_r : lp_r + POS_W'(1);
  assign n_act      = (32'(svc_r) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES) : CNT_W'(svc_r);

  always_comb begin
    tok_nxt    = '0;
    tok_nxt.op = OP_NONE;
    tok_nxt.n  = n_act;
    active_nxt = active_r;
    lp_nxt     = lp_r;
    bytes_nxt  = bytes_r;
    ticks_nxt  = ticks_r;
    if (accept) begin
      case (in_command)
        CMD_LOAD: begin
          if ((32'(in_entry_index) < MAX_ENTRIES) && (32'(in_char_position) < NAME_LEN)) begin
            tok_nxt.op    = OP_LOAD;
            tok_nxt.entry = in_entry_index;
            tok_nxt.pos   = POS_W'(in_char_position);
            tok_nxt.data  = in_byte_value;
            tok_nxt.wr    = in_writable;
          end
        end
        CMD_START: begin
          active_nxt = 1'b1;
          lp_nxt     = '0;
          bytes_nxt  = '0;
          ticks_nxt  = '0;
          tok_nxt.op = OP_START;
        end
        CMD_TICK: begin
          if (active_r) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc >= max_time_r) begin
              active_nxt      = 1'b0;
              tok_nxt.op      = OP_RES;
              tok_nxt.res     = 1'b1;
              tok_nxt.outcome = OC_LIMIT;
            end
          end
        end
        CMD_DATA: begin
          if (active_r) begin
            if (over) begin
              active_nxt      = 1'b0;
              tok_nxt.op      = OP_RES;
              tok_nxt.res     = 1'b1;
              tok_nxt.outcome = OC_LIMIT;
            end else begin
              bytes_nxt = bytes_inc;
              if (in_byte_value == CH_SPACE) begin
                active_nxt      = 1'b0;
                tok_nxt.op      = OP_RES;
                tok_nxt.res     = 1'b1;
                tok_nxt.outcome = OC_END;
              end else if (in_byte_value == CH_EQUALS) begin
                active_nxt  = 1'b0;
                tok_nxt.op  = OP_EQ;
                tok_nxt.res = 1'b1;
                tok_nxt.pos = lp_r;
              end else begin
                lp_nxt       = lp_inc;
                tok_nxt.op   = OP_LETTER;
                tok_nxt.pos  = lp_r;
                tok_nxt.data = in_byte_value;
                if (over_after) begin
                  active_nxt      = 1'b0;
                  tok_nxt.res     = 1'b1;
                  tok_nxt.outcome = OC_LIMIT;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= MAX_BYTES_RST;
      max_time_r  <= MAX_TIME_RST;
      svc_r       <= SERVICES_RST;
      active_r    <= 1'b0;
      lp_r        <= '0;
      bytes_r     <= '0;
      ticks_r     <= '0;
      tok_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_BYTES: max_bytes_r <= cfg_wdata;
          CFG_MAX_TIME:  max_time_r  <= cfg_wdata;
          CFG_SERVICES:  svc_r       <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      active_r <= active_nxt;
      lp_r     <= lp_nxt;
      bytes_r  <= bytes_nxt;
      ticks_r  <= ticks_nxt;
      if (adv) begin
        tok_r <= tok_nxt;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

/* design/keyword_table_prefix_matcher.sv */
// channel | handshake            | payload
// --------+----------------------+--------------------------------------------------
// in      | in_valid / in_ready  | in_command, in_entry_index, in_char_position,
//         |                      | in_byte_value, in_writable
// out     | out_valid / out_ready| out_outcome, out_service_index
// cfg     | cfg_we               | cfg_index, cfg_wdata
//
// One transaction per cycle in while in_ready is high; a result passes the head register,
// the two stages of each cell and the output register.
// Synchronous active-low reset clears control state; the name RAMs are not cleared.
// A waiting result does not block input; a second result arriving behind it
// goes to a skid register, and in_ready drops until the first is taken.
module keyword_table_prefix_matcher
  import kwm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int NAME_LEN    = NAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_entry_index,
  input  logic [3:0]  in_char_position,
  input  logic [7:0]  in_byte_value,
  input  logic        in_writable,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [2:0]  out_service_index
);

  kwm_tok_t   chain [MAX_ENTRIES+1];
  kwm_tok_t   tail;
  logic       adv;
  logic       accept;
  logic       out_v_r, skid_v_r;
  logic [1:0] out_oc_r, skid_oc_r, tail_oc;
  logic [2:0] out_idx_r, skid_idx_r, tail_idx;

  assign adv      = !skid_v_r;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  kwm_head #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NAME_LEN    (NAME_LEN)
  ) u_head (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .accept           (accept),
    .adv              (adv),
    .in_command       (in_command),
    .in_entry_index   (in_entry_index),
    .in_char_position (in_char_position),
    .in_byte_value    (in_byte_value),
    .in_writable      (in_writable),
    .tok_o            (chain[0])
  );

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    kwm_cell #(
      .CELL_IDX (g),
      .NAME_LEN (NAME_LEN)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign tail     = chain[MAX_ENTRIES];
  assign tail_oc  = (tail.op == OP_EQ) ? (tail.found ? OC_MATCH : OC_NO_MATCH) : tail.outcome;
  assign tail_idx = ((tail.op == OP_EQ) && tail.found) ? tail.idx : 3'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        out_oc_r  <= skid_oc_r;
        out_idx_r <= skid_idx_r;
        skid_v_r  <= 1'b0;
      end
    end else if (tail.res) begin
      if (!out_v_r || out_ready) begin
        out_v_r   <= 1'b1;
        out_oc_r  <= tail_oc;
        out_idx_r <= tail_idx;
      end else begin
        skid_v_r   <= 1'b1;
        skid_oc_r  <= tail_oc;
        skid_idx_r <= tail_idx;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid         = out_v_r;
  assign out_outcome       = out_oc_r;
  assign out_service_index = out_idx_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while the output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid register filled while the output was free");

  a_idx_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_oc_r != OC_MATCH)) |-> (out_idx_r == 3'd0))
    else $error("service index set on a result that is not a match");

  a_found_on_eq: assert property (@(posedge clk) disable iff (!rst_n)
    tail.found |-> ((tail.op == OP_EQ) && tail.res))
    else $error("match flag on a transaction that is not an equals sign");

endmodule

/* tb/sv/kwm_tb_pkg.sv */
`timescale 1ns / 100ps
package kwm_tb_pkg;
  import kwm_pkg::*;

  localparam int N_ENTRIES = MAX_ENTRIES_DEF;
  localparam int N_CHARS   = NAME_LEN_DEF;

  typedef struct {
    logic [1:0] outcome;
    logic [2:0] service;
  } match_result_t;

  class match_scoreboard;
    logic [7:0]           names [N_ENTRIES][N_CHARS];
    bit [N_ENTRIES-1:0]   writable_bits;
    bit [N_ENTRIES-1:0]   candidates;
    int unsigned          letter_pos;
    bit [15:0]            bytes_seen;
    bit [15:0]            ticks_seen;
    bit [15:0]            byte_limit;
    bit [15:0]            tick_limit;
    bit [3:0]             services;
    bit                   active;
    match_result_t        expected_outcomes[$];
    int                   errors;

    function new();
      foreach (names[e, p]) names[e][p] = CH_NUL;
      writable_bits = '0;
      candidates    = '0;
      letter_pos    = 0;
      bytes_seen    = '0;
      ticks_seen    = '0;
      active        = 1'b0;
      byte_limit    = MAX_BYTES_RST;
      tick_limit    = MAX_TIME_RST;
      services      = SERVICES_RST;
      errors        = 0;
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    function void write_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_MAX_BYTES: byte_limit = value;
        CFG_MAX_TIME:  tick_limit = value;
        CFG_SERVICES:  services = value[3:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] char_at(int unsigned entry, int unsigned pos);
      if (pos >= N_CHARS) return CH_NUL;
      return names[entry][pos];
    endfunction

    function bit over_limit();
      return (bytes_seen >= byte_limit) || (ticks_seen >= tick_limit);
    endfunction

    function void report(logic [1:0] outcome, logic [2:0] service);
      match_result_t r;
      r.outcome = outcome;
      r.service = service;
      active = 1'b0;
      expected_outcomes.push_back(r);
    endfunction

    function void note_transaction(logic [1:0] cmd, logic [2:0] entry, logic [3:0] pos,
                                   logic [7:0] data, logic wr);
      int unsigned n;
      bit [N_ENTRIES-1:0] in_use;
      n = (services > N_ENTRIES) ? N_ENTRIES : services;
      in_use = '0;
      for (int i = 0; i < n; i++) in_use[i] = 1'b1;
      case (cmd)
        CMD_LOAD: begin
          names[entry][pos]    = data;
          writable_bits[entry] = wr;
        end
        CMD_START: begin
          bytes_seen = '0;
          ticks_seen = '0;
          letter_pos = 0;
          candidates = writable_bits & in_use;
          active     = 1'b1;
        end
        CMD_TICK: begin
          if (active) begin
            if (ticks_seen != 16'hFFFF) ticks_seen++;
            if (ticks_seen >= tick_limit) report(OC_LIMIT, 3'd0);
          end
        end
        default: begin
          if (active) begin
            if (over_limit()) begin
              report(OC_LIMIT, 3'd0);
            end else begin
              bytes_seen++;
              if (data == CH_SPACE) begin
                report(OC_END, 3'd0);
              end else if (data == CH_EQUALS) begin
                for (int i = 0; i < n && active; i++) begin
                  if (candidates[i] && char_at(i, letter_pos) == CH_NUL)
                    report(OC_MATCH, 3'(i));
                end
                if (active) report(OC_NO_MATCH, 3'd0);
              end else begin
                for (int i = 0; i < n; i++) begin
                  if (candidates[i] && char_at(i, letter_pos) != data) candidates[i] = 1'b0;
                end
                if (letter_pos < N_CHARS) letter_pos++;
                if (over_limit()) report(OC_LIMIT, 3'd0);
              end
            end
          end
        end
      endcase
    endfunction

    function void check_result(logic [1:0] outcome, logic [2:0] service);
      match_result_t exp;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual outcome %0d service %0d",
                 $time, outcome, service);
        errors++;
        return;
      end
      exp = expected_outcomes.pop_front();
      if (outcome !== exp.outcome) begin
        $display("%0t: outcome mismatch, expected %0d actual %0d", $time, exp.outcome, outcome);
        errors++;
      end
      if (service !== exp.service) begin
        $display("%0t: service index mismatch, expected %0d actual %0d",
                 $time, exp.service, service);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
  import kwm_pkg::*;
  import kwm_tb_pkg::*;

  localparam int LATENCY_PAD = 2 * MAX_ENTRIES_DEF + 24;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [2:0]  in_entry_index = '0;
  logic [3:0]  in_char_position = '0;
  logic [7:0]  in_byte_value = '0;
  logic        in_writable = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_outcome;
  logic [2:0]  out_service_index;

  match_scoreboard sb;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int burst_left = 0;
  int quiet_cycles = 0;

  string keywords [N_ENTRIES] = '{"led", "lamp", "lampx", "temp", "led", "t", "",
                                  "abcdefghijklmnop"};
  string letters = "aelmptx";

  keyword_table_prefix_matcher uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_entry_index    (in_entry_index),
    .in_char_position  (in_char_position),
    .in_byte_value     (in_byte_value),
    .in_writable       (in_writable),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_outcome       (out_outcome),
    .out_service_index (out_service_index)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall patterns of random length, plus one long hold
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(1, 64);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ~out_ready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_ready)
        sb.check_result(out_outcome, out_service_index);
      if (in_valid && in_ready === 1'b1)
        sb.note_transaction(in_command, in_entry_index, in_char_position, in_byte_value,
                            in_writable);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task send_item(input logic [1:0] cmd, input logic [2:0] entry, input logic [3:0] pos,
                 input logic [7:0] data, input logic wr);
    if (burst_left == 0) begin
      if ($urandom_range(0, 19) == 0) idle_for($urandom_range(20, 40));
      else idle_for($urandom_range(1, 8));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_entry_index   <= entry;
    in_char_position <= pos;
    in_byte_value    <= data;
    in_writable      <= wr;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task send_cmd(input logic [1:0] cmd);
    send_item(cmd, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task send_data(input logic [7:0] data);
    send_item(CMD_DATA, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), data,
              1'($urandom_range(0, 1)));
  endtask

  task send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_data(s[k]);
  endtask

  task load_name(input int entry, input string s, input bit wr);
    for (int p = 0; p < N_CHARS; p++)
      send_item(CMD_LOAD, 3'(entry), 4'(p), (p < s.len()) ? s[p] : CH_NUL, wr);
  endtask

  task load_random();
    logic [7:0] ch;
    case ($urandom_range(0, 3))
      0: ch = CH_NUL;
      1: ch = 8'($urandom_range(0, 255));
      default: ch = letters[$urandom_range(0, letters.len() - 1)];
    endcase
    send_item(CMD_LOAD, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), ch,
              ($urandom_range(0, 9) < 7));
  endtask

  // start, a prefix of one stored name (bytes sometimes randomised) with ticks mixed in, then usually a terminator
  task run_session();
    int t;
    int len;
    int stop;
    int ending;
    logic [7:0] ch;
    t = $urandom_range(0, N_ENTRIES - 1);
    len = 0;
    while (len < N_CHARS && sb.names[t][len] != CH_NUL) len++;
    stop = ($urandom_range(0, 9) < 7) ? len : $urandom_range(0, len);
    send_cmd(CMD_START);
    for (int k = 0; k < stop; k++) begin
      if ($urandom_range(0, 6) == 0) send_cmd(CMD_TICK);
      ch = sb.names[t][k];
      if ($urandom_range(0, 19) == 0) ch = 8'($urandom_range(0, 255));
      send_data(ch);
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) send_data(CH_NUL);
    ending = $urandom_range(0, 19);
    if (ending < 14) send_data(CH_EQUALS);
    else if (ending < 17) send_data(CH_SPACE);
  endtask

  task run_random(input int count);
    int target;
    int r;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) load_random();
      else if (r < 16) send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                                 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
      else run_session();
    end
  endtask

  task wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task write_cfg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    sb.write_register(idx, value);
  endtask

  task set_config(input logic [15:0] mb, input logic [15:0] mt, input logic [3:0] svc);
    wait_all_results();
    repeat (LATENCY_PAD) @(posedge clk);
    write_cfg(CFG_MAX_BYTES, mb);
    write_cfg(CFG_MAX_TIME, mt);
    write_cfg(CFG_SERVICES, {12'($urandom), svc});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int e = 0; e < N_ENTRIES; e++) load_name(e, keywords[e], e != 3);

    // idle data and tick are dropped
    send_text("x");
    send_cmd(CMD_TICK);
    // empty name
    send_cmd(CMD_START);
    send_data(CH_EQUALS);
    // duplicate name, lowest index wins
    send_cmd(CMD_START);
    send_text("led");
    send_data(CH_EQUALS);
    // restart mid-name
    send_cmd(CMD_START);
    send_text("l");
    send_cmd(CMD_START);
    send_text("t");
    send_data(CH_EQUALS);
    send_cmd(CMD_START);
    send_text("ti");
    send_data(CH_SPACE);
    // zero byte compared as a letter
    send_cmd(CMD_START);
    send_text("t");
    send_data(CH_NUL);
    send_data(CH_EQUALS);
    // read-only entry is never a candidate
    send_cmd(CMD_START);
    send_text("temp");
    send_data(CH_EQUALS);
    send_item(CMD_LOAD, 3'd7, 4'd15, 8'hFF, 1'b1);
    send_cmd(CMD_START);
    send_text("lamp");
    send_data(CH_EQUALS);

    run_random(330);
    set_config(16'd65535, 16'd65535, 4'd8);
    run_random(300);
    set_config(16'd1, 16'd1, 4'd15);
    run_random(150);
    set_config(16'd6, 16'd12, 4'd3);
    run_random(300);
    set_config(16'd20, 16'd30, 4'd0);
    write_cfg(CFG_UNUSED, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    run_random(150);
    set_config(16'd64, 16'd200, 4'd5);
    hold_req = 1'b1;
    run_random(250);
    wait_all_results();
    run_random(250);

    wait_all_results();
    repeat (LATENCY_PAD) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
